// ----- hdl/ide_pkg.sv -----
// Package for the indexed deque engine: widths, codes, beat structs, slot math.
package ide_pkg;

	// Storage geometry
	localparam int CAPACITY = 64;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	// Field widths
	localparam int REQ_W  = 3;
	localparam int VAL_W  = 32;
	localparam int POS_W  = 7;
	localparam int ST_W   = 2;
	localparam int SIZE_W = 7;

	// Width that holds both a position and a count, for compares
	localparam int WIDE_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	// Stream bus widths, packed to whole bytes
	localparam int S_DATA_W = ((VAL_W + POS_W + 7) / 8) * 8;
	localparam int M_DATA_W = ((VAL_W + SIZE_W + 7) / 8) * 8;

	// Request codes
	typedef enum logic [REQ_W-1:0] {
		REQ_PUSH_BACK  = 3'd0,
		REQ_PUSH_FRONT = 3'd1,
		REQ_POP_FRONT  = 3'd2,
		REQ_POP_BACK   = 3'd3,
		REQ_RESIZE     = 3'd4,
		REQ_READ       = 3'd5,
		REQ_WRITE      = 3'd6,
		REQ_DUMP       = 3'd7
	} req_type_t;

	// Status codes
	typedef enum logic [ST_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	// One request beat
	typedef struct packed {
		req_type_t               req_type;
		logic signed [VAL_W-1:0] value_in;
		logic [POS_W-1:0]        position;
	} req_t;

	// One result beat
	typedef struct packed {
		logic signed [VAL_W-1:0] value_out;
		status_t                 status;
		logic                    last;
		logic [SIZE_W-1:0]       size_now;
	} res_t;

	// Store slot of element idx: head plus idx, wrapped at the capacity
	function automatic logic [ADDR_W-1:0] slot_of(input logic [ADDR_W-1:0] head,
	                                               input logic [CNT_W-1:0] idx);
		logic [ADDR_W:0] sum;
		sum = {1'b0, head} + (ADDR_W+1)'(idx);
		if (sum >= (ADDR_W+1)'(CAPACITY)) begin
			sum = sum - (ADDR_W+1)'(CAPACITY);
		end
		return sum[ADDR_W-1:0];
	endfunction

endpackage

// ----- hdl/indexed_deque_engine_top.sv -----
// Top level of the indexed deque engine: stream ports, store, controller, output register.
//
//  channel | dir | tdata (low bit up)           | tuser       | tlast
//  s_axis  | in  | value_in[31:0], position[6:0]| req_type    | -
//  m_axis  | out | value_out[31:0], size_now    | status      | last
//
// Push, pop, write, shrinking resize and any flagged request: result loaded in the cycle of accept.
// Read: the store's registered read port is read on accept, and the result is loaded from S_READ.
// Dump of n elements: one element per cycle through the read port while the sink takes results.
// Growing resize from n to m elements: one zero write per cycle in S_FILL, then the result.
// Reset clears the sequencer state, head, count and output valid; the store has no clearing pass.
// A result waits in the output register; a stalled sink holds the sequencer.
module indexed_deque_engine_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [ide_pkg::S_DATA_W-1:0] s_axis_tdata,  // value_in, position, zero pad
	input  logic [ide_pkg::REQ_W-1:0]    s_axis_tuser,  // req_type
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [ide_pkg::M_DATA_W-1:0] m_axis_tdata,  // value_out, size_now, zero pad
	output logic [ide_pkg::ST_W-1:0]     m_axis_tuser,  // status
	output logic                         m_axis_tlast
);

	ide_pkg::req_t              req;
	ide_pkg::res_t              res;
	ide_pkg::res_t              out_q;
	logic                       m_valid_q;
	logic                       out_free;
	logic                       res_load;
	logic                       ram_we, ram_re;
	logic [ide_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [ide_pkg::VAL_W-1:0]  ram_wdata, ram_rdata;

	// Unpack the request beat
	assign req.req_type = ide_pkg::req_type_t'(s_axis_tuser);
	assign req.value_in = s_axis_tdata[ide_pkg::VAL_W-1:0];
	assign req.position = s_axis_tdata[ide_pkg::VAL_W +: ide_pkg::POS_W];

	assign out_free = !m_valid_q || m_axis_tready;

	ide_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_axis_tvalid),
		.req_ready (s_axis_tready),
		.req       (req),
		.out_free  (out_free),
		.res_load  (res_load),
		.res       (res),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	ide_ram #(
		.DATA_W (ide_pkg::VAL_W),
		.DEPTH  (ide_pkg::CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_load) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (res_load) begin
			out_q <= res;
		end
	end

	// Pack the result beat
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = ide_pkg::M_DATA_W'({out_q.size_now, out_q.value_out});
	assign m_axis_tuser  = out_q.status;
	assign m_axis_tlast  = out_q.last;

endmodule

// ----- hdl/ide_ram.sv -----
// Simple dual-port synchronous RAM, one write and one registered read port.
module ide_ram #(
	parameter int DATA_W = 32,
	parameter int DEPTH  = 64
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  logic [DATA_W-1:0]          wdata,
	input  logic                       re,
	input  logic [$clog2(DEPTH)-1:0]   raddr,
	output logic [DATA_W-1:0]          rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- hdl/ide_ctrl.sv -----
// Deque controller: head and count, request decode, fill and read sequencer.
module ide_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	// request side
	input  logic                       req_valid,
	output logic                       req_ready,
	input  ide_pkg::req_t              req,
	// result side
	input  logic                       out_free,
	output logic                       res_load,
	output ide_pkg::res_t              res,
	// store access
	output logic                       ram_we,
	output logic [ide_pkg::ADDR_W-1:0] ram_waddr,
	output logic [ide_pkg::VAL_W-1:0]  ram_wdata,
	output logic                       ram_re,
	output logic [ide_pkg::ADDR_W-1:0] ram_raddr,
	input  logic [ide_pkg::VAL_W-1:0]  ram_rdata
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_READ = 3'b010,
		S_FILL = 3'b100
	} state_t;

	state_t                      state_q, state_d;
	logic [ide_pkg::ADDR_W-1:0]  head_q, head_d;
	logic [ide_pkg::CNT_W-1:0]   count_q, count_d;
	logic [ide_pkg::CNT_W-1:0]   idx_q, idx_d;
	logic [ide_pkg::CNT_W-1:0]   end_q, end_d;
	logic                        dump_q, dump_d;

	logic                        accept;
	logic                        full, empty;
	logic [ide_pkg::WIDE_W-1:0]  pos_w, cnt_w, cap_w;
	logic [ide_pkg::CNT_W-1:0]   pos_c;
	logic [ide_pkg::CNT_W-1:0]   idx_inc;
	logic [ide_pkg::ADDR_W-1:0]  head_dec, head_inc;

	assign req_ready = (state_q == S_IDLE) && out_free;
	assign accept    = req_valid && req_ready;

	assign full  = (count_q == ide_pkg::CNT_W'(ide_pkg::CAPACITY));
	assign empty = (count_q == '0);

	assign pos_w = ide_pkg::WIDE_W'(req.position);
	assign cnt_w = ide_pkg::WIDE_W'(count_q);
	assign cap_w = ide_pkg::WIDE_W'(ide_pkg::CAPACITY);
	assign pos_c = ide_pkg::CNT_W'(pos_w);

	assign idx_inc = idx_q + ide_pkg::CNT_W'(1);

	// Head moves with wrap at the capacity
	assign head_dec = (head_q == '0) ? ide_pkg::ADDR_W'(ide_pkg::CAPACITY - 1)
	                                 : head_q - ide_pkg::ADDR_W'(1);
	assign head_inc = (head_q == ide_pkg::ADDR_W'(ide_pkg::CAPACITY - 1)) ? '0
	                                 : head_q + ide_pkg::ADDR_W'(1);

	// Decode, store access and result
	always_comb begin
		state_d   = state_q;
		head_d    = head_q;
		count_d   = count_q;
		idx_d     = idx_q;
		end_d     = end_q;
		dump_d    = dump_q;
		ram_we    = 1'b0;
		ram_waddr = ide_pkg::slot_of(head_q, count_q);
		ram_wdata = req.value_in;
		ram_re    = 1'b0;
		ram_raddr = ide_pkg::slot_of(head_q, pos_c);
		res_load  = 1'b0;
		res.value_out = '0;
		res.status    = ide_pkg::ST_OK;
		res.last      = 1'b1;
		res.size_now  = ide_pkg::SIZE_W'(count_q);

		case (state_q)
			S_IDLE: begin
				if (accept) begin
					res_load = 1'b1;
					case (req.req_type)
						ide_pkg::REQ_PUSH_BACK: begin
							if (full) begin
								res.status = ide_pkg::ST_FULL;
							end else begin
								ram_we  = 1'b1;
								count_d = count_q + ide_pkg::CNT_W'(1);
							end
						end
						ide_pkg::REQ_PUSH_FRONT: begin
							if (full) begin
								res.status = ide_pkg::ST_FULL;
							end else begin
								ram_we    = 1'b1;
								ram_waddr = head_dec;
								head_d    = head_dec;
								count_d   = count_q + ide_pkg::CNT_W'(1);
							end
						end
						ide_pkg::REQ_POP_FRONT: begin
							if (empty) begin
								res.status = ide_pkg::ST_EMPTY;
							end else begin
								head_d  = head_inc;
								count_d = count_q - ide_pkg::CNT_W'(1);
							end
						end
						ide_pkg::REQ_POP_BACK: begin
							if (empty) begin
								res.status = ide_pkg::ST_EMPTY;
							end else begin
								count_d = count_q - ide_pkg::CNT_W'(1);
							end
						end
						ide_pkg::REQ_RESIZE: begin
							if (pos_w > cap_w) begin
								res.status = ide_pkg::ST_FULL;
							end else if (pos_w <= cnt_w) begin
								count_d = pos_c;
							end else begin
								// grow: zero the new entries first
								res_load = 1'b0;
								idx_d    = count_q;
								end_d    = pos_c;
								state_d  = S_FILL;
							end
						end
						ide_pkg::REQ_READ: begin
							if (pos_w >= cnt_w) begin
								res.status = ide_pkg::ST_RANGE;
							end else begin
								res_load = 1'b0;
								ram_re   = 1'b1;
								dump_d   = 1'b0;
								state_d  = S_READ;
							end
						end
						ide_pkg::REQ_WRITE: begin
							if (pos_w >= cnt_w) begin
								res.status = ide_pkg::ST_RANGE;
							end else begin
								ram_we    = 1'b1;
								ram_waddr = ide_pkg::slot_of(head_q, pos_c);
							end
						end
						ide_pkg::REQ_DUMP: begin
							if (empty) begin
								res.status = ide_pkg::ST_EMPTY;
							end else begin
								res_load  = 1'b0;
								ram_re    = 1'b1;
								ram_raddr = head_q;
								idx_d     = '0;
								dump_d    = 1'b1;
								state_d   = S_READ;
							end
						end
						default: begin
							res.status = ide_pkg::ST_OK;
						end
					endcase
					res.size_now = ide_pkg::SIZE_W'(count_d);
				end
			end
			S_READ: begin
				// read data is valid here; hand it on when the slot is free
				res.value_out = ram_rdata;
				res.last      = !dump_q || (idx_inc == count_q);
				if (out_free) begin
					res_load = 1'b1;
					if (res.last) begin
						state_d = S_IDLE;
					end else begin
						idx_d     = idx_inc;
						ram_re    = 1'b1;
						ram_raddr = ide_pkg::slot_of(head_q, idx_inc);
					end
				end
			end
			S_FILL: begin
				// one zero entry per cycle; result slot is free since accept
				ram_we    = 1'b1;
				ram_waddr = ide_pkg::slot_of(head_q, idx_q);
				ram_wdata = '0;
				idx_d     = idx_inc;
				if (idx_inc == end_q) begin
					count_d      = end_q;
					res_load     = 1'b1;
					res.size_now = ide_pkg::SIZE_W'(end_q);
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			count_q <= count_d;
		end
	end

	// Sequencer working registers
	always_ff @(posedge clk) begin
		idx_q  <= idx_d;
		end_q  <= end_d;
		dump_q <= dump_d;
	end

endmodule

// ----- test/ide_checker.sv -----
// Result checker for the indexed deque engine: tracks the deque and compares every result beat.
module ide_checker
	import ide_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	input  logic                s_axis_tready,
	input  logic [S_DATA_W-1:0] s_axis_tdata,   // value_in, position, zero pad
	input  logic [REQ_W-1:0]    s_axis_tuser,   // req_type
	input  logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	input  logic [M_DATA_W-1:0] m_axis_tdata,   // value_out, size_now, zero pad
	input  logic [ST_W-1:0]     m_axis_tuser,   // status
	input  logic                m_axis_tlast,
	output int                  fail_count,
	output int                  pending,
	output int                  occupancy,
	output int                  beats_checked,
	output int                  flagged_beats
);
	timeunit 1ns;
	timeprecision 1ps;

	// Mirror of the deque: circular store, front slot and element count
	logic signed [VAL_W-1:0] deque_mem [CAPACITY];
	int front_slot = 0;
	int depth = 0;

	// Result beats still owed by the block, oldest first
	res_t owed_results [$];

	initial begin
		fail_count = 0;
		pending = 0;
		occupancy = 0;
		beats_checked = 0;
		flagged_beats = 0;
	end

	function automatic int slot_at(int idx);
		return (front_slot + idx) % CAPACITY;
	endfunction

	function automatic void owe_result(logic signed [VAL_W-1:0] value, status_t st, logic lst);
		res_t r;
		r.value_out = value;
		r.status = st;
		r.last = lst;
		r.size_now = SIZE_W'(depth);
		owed_results.insert(owed_results.size(), r);
	endfunction

	// Apply one request to the mirror and queue the beats it must produce
	function automatic void apply_request(req_type_t op, logic signed [VAL_W-1:0] value,
	                                      logic [POS_W-1:0] pos);
		logic signed [VAL_W-1:0] rd;
		status_t st;
		int target;
		rd = '0;
		st = ST_OK;
		target = int'(pos);
		case (op)
			REQ_PUSH_BACK: begin
				if (depth >= CAPACITY) begin
					st = ST_FULL;
				end else begin
					deque_mem[slot_at(depth)] = value;
					depth++;
				end
			end
			REQ_PUSH_FRONT: begin
				if (depth >= CAPACITY) begin
					st = ST_FULL;
				end else begin
					front_slot = (front_slot + CAPACITY - 1) % CAPACITY;
					deque_mem[front_slot] = value;
					depth++;
				end
			end
			REQ_POP_FRONT: begin
				if (depth == 0) begin
					st = ST_EMPTY;
				end else begin
					front_slot = (front_slot + 1) % CAPACITY;
					depth--;
				end
			end
			REQ_POP_BACK: begin
				if (depth == 0) begin
					st = ST_EMPTY;
				end else begin
					depth--;
				end
			end
			REQ_RESIZE: begin
				if (target > CAPACITY) begin
					st = ST_FULL;
				end else begin
					// growth appends zeros at the back
					for (int k = depth; k < target; k++) begin
						deque_mem[slot_at(k)] = '0;
					end
					depth = target;
				end
			end
			REQ_READ: begin
				if (target >= depth) begin
					st = ST_RANGE;
				end else begin
					rd = deque_mem[slot_at(target)];
				end
			end
			REQ_WRITE: begin
				if (target >= depth) begin
					st = ST_RANGE;
				end else begin
					deque_mem[slot_at(target)] = value;
				end
			end
			REQ_DUMP: begin
				if (depth == 0) begin
					st = ST_EMPTY;
				end else begin
					// front to back, last marks the final element
					for (int k = 0; k < depth; k++) begin
						owe_result(deque_mem[slot_at(k)], ST_OK, k == depth - 1);
					end
					return;
				end
			end
		endcase
		owe_result(rd, st, 1'b1);
	endfunction

	// Compare one result beat against the oldest owed one
	function automatic void check_beat();
		res_t want;
		logic signed [VAL_W-1:0] got_value;
		logic [SIZE_W-1:0] got_size;
		got_value = m_axis_tdata[VAL_W-1:0];
		got_size = m_axis_tdata[VAL_W +: SIZE_W];
		beats_checked++;
		if (m_axis_tuser != ST_OK) begin
			flagged_beats++;
		end
		if (owed_results.size() == 0) begin
			$error("unexpected result beat: value_out %0d status %0d last %0b size_now %0d",
			       got_value, m_axis_tuser, m_axis_tlast, got_size);
			fail_count++;
			return;
		end
		want = owed_results[0];
		owed_results.delete(0);
		if (got_value !== want.value_out) begin
			$error("value_out: expected %0d, actual %0d", want.value_out, got_value);
			fail_count++;
		end
		if (m_axis_tuser !== want.status) begin
			$error("status: expected %0d, actual %0d", want.status, m_axis_tuser);
			fail_count++;
		end
		if (m_axis_tlast !== want.last) begin
			$error("last: expected %0b, actual %0b", want.last, m_axis_tlast);
			fail_count++;
		end
		if (got_size !== want.size_now) begin
			$error("size_now: expected %0d, actual %0d", want.size_now, got_size);
			fail_count++;
		end
	endfunction

	// Watch both channels at each edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_slot = 0;
			depth = 0;
			owed_results.delete();
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				apply_request(req_type_t'(s_axis_tuser), s_axis_tdata[VAL_W-1:0],
				              s_axis_tdata[VAL_W +: POS_W]);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				check_beat();
			end
		end
		pending = owed_results.size();
		occupancy = depth;
	end

endmodule

// ----- test/testbench.sv -----
// Testbench top for the indexed deque engine: clock, reset, request stimulus, sink and verdict.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import ide_pkg::*;

	localparam int IDLE_LIMIT   = 3000;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 100;
	localparam int SEGMENTS     = 6;
	localparam int SEG_ITEMS    = 29;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [S_DATA_W-1:0] s_axis_tdata = '0;
	logic [REQ_W-1:0]    s_axis_tuser = '0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [M_DATA_W-1:0] m_axis_tdata;
	logic [ST_W-1:0]     m_axis_tuser;
	logic                m_axis_tlast;

	bit idle_on = 1'b1;
	bit hold_sink = 1'b0;
	int quiet_cycles = 0;
	int sent_per_op [8] = '{default: 0};
	int fail_count, pending, occupancy, beats_checked, flagged_beats;

	always #5 clk = ~clk;

	indexed_deque_engine_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	ide_checker results_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.fail_count    (fail_count),
		.pending       (pending),
		.occupancy     (occupancy),
		.beats_checked (beats_checked),
		.flagged_beats (flagged_beats)
	);

	// Offer one request beat, with an optional gap first, and wait until it is taken
	task automatic send_request(input req_type_t op, input logic signed [VAL_W-1:0] value,
	                            input int pos);
		int gap;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 14);
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= S_DATA_W'({$urandom, $urandom});
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= S_DATA_W'({POS_W'(pos), value});
		do @(posedge clk); while (!s_axis_tready);
		sent_per_op[op]++;
	endtask

	// Random request, biased toward growing or shrinking the deque
	task automatic random_request(input bit grow);
		int pick, occ, pos, r, top_size;
		req_type_t op;
		logic signed [VAL_W-1:0] value;
		occ = occupancy;
		value = $urandom;
		pick = $urandom_range(0, 99);
		if (grow) begin
			if (pick < 28) op = REQ_PUSH_BACK;
			else if (pick < 46) op = REQ_PUSH_FRONT;
			else if (pick < 52) op = REQ_POP_FRONT;
			else if (pick < 58) op = REQ_POP_BACK;
			else if (pick < 66) op = REQ_RESIZE;
			else if (pick < 80) op = REQ_READ;
			else if (pick < 92) op = REQ_WRITE;
			else op = REQ_DUMP;
		end else begin
			if (pick < 10) op = REQ_PUSH_BACK;
			else if (pick < 18) op = REQ_PUSH_FRONT;
			else if (pick < 36) op = REQ_POP_FRONT;
			else if (pick < 54) op = REQ_POP_BACK;
			else if (pick < 62) op = REQ_RESIZE;
			else if (pick < 78) op = REQ_READ;
			else if (pick < 90) op = REQ_WRITE;
			else op = REQ_DUMP;
		end
		pos = $urandom_range(0, 127);
		if (op == REQ_READ || op == REQ_WRITE) begin
			if (occ > 0 && $urandom_range(0, 9) < 8) begin
				pos = $urandom_range(0, occ - 1);
			end
		end else if (op == REQ_RESIZE) begin
			r = $urandom_range(0, 9);
			top_size = (occ + 6 > CAPACITY) ? CAPACITY : occ + 6;
			if (r < 7) pos = grow ? $urandom_range(0, top_size) : $urandom_range(0, occ);
			else if (r == 7) pos = CAPACITY;
			else if (r == 8) pos = occ;
			else pos = $urandom_range(CAPACITY + 1, 127);
		end
		send_request(op, value, pos);
	endtask

	// Result sink: random stalls, one long hold-off on request
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_sink) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_sink = 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Watchdog: too long without any beat on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// Stimulus and verdict
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty deque: pops, dump, index and size errors
		send_request(REQ_POP_FRONT, 0, 0);
		send_request(REQ_POP_BACK, -1, 127);
		send_request(REQ_DUMP, 0, 0);
		send_request(REQ_READ, 0, 0);
		send_request(REQ_WRITE, 32'sh7FFFFFFF, 0);
		send_request(REQ_RESIZE, 0, 65);
		send_request(REQ_RESIZE, 32'sh80000000, 127);
		// pushes at both ends with extreme words
		send_request(REQ_PUSH_BACK, 32'sh7FFFFFFF, 0);
		send_request(REQ_PUSH_FRONT, 32'sh80000000, 64);
		send_request(REQ_PUSH_BACK, -1, 0);
		send_request(REQ_PUSH_FRONT, 0, 0);
		send_request(REQ_READ, 0, 0);
		send_request(REQ_READ, 0, 3);
		send_request(REQ_READ, 0, 4);
		send_request(REQ_WRITE, 32'sh55555555, 1);
		send_request(REQ_WRITE, 0, 4);
		send_request(REQ_DUMP, 0, 0);
		// resize to same size, grow, shrink
		send_request(REQ_RESIZE, 0, 4);
		send_request(REQ_RESIZE, 0, 7);
		send_request(REQ_RESIZE, 0, 2);
		send_request(REQ_POP_BACK, 0, 0);
		send_request(REQ_POP_FRONT, 0, 0);
		// fill to capacity, then pushes that must be refused
		send_request(REQ_RESIZE, 0, 64);
		send_request(REQ_PUSH_BACK, 32'shAAAAAAAA, 0);
		send_request(REQ_PUSH_FRONT, 1, 0);
		send_request(REQ_WRITE, 32'sh80000000, 63);
		send_request(REQ_READ, 0, 63);
		send_request(REQ_RESIZE, 0, 0);

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			// a stretch in the middle and the closing stretch run without gaps
			idle_on = (seg != 3 && seg != SEGMENTS - 1);
			for (int i = 0; i < SEG_ITEMS; i++) begin
				random_request(seg % 2 == 0);
			end
			if (seg == 1) begin
				// full deque dumped while the sink holds off, so the input backs up
				send_request(REQ_RESIZE, 0, 40);
				for (int i = 0; i < 24; i++) begin
					send_request(REQ_PUSH_FRONT, $urandom, 0);
				end
				hold_sink = 1'b1;
				send_request(REQ_DUMP, 0, 0);
				send_request(REQ_PUSH_BACK, $urandom, 0);
				send_request(REQ_POP_FRONT, 0, 0);
				send_request(REQ_DUMP, 0, 0);
			end
		end

		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d requests: push %0d, pop %0d, resize %0d,",
		         sent_per_op.sum(), sent_per_op[REQ_PUSH_BACK] + sent_per_op[REQ_PUSH_FRONT],
		         sent_per_op[REQ_POP_FRONT] + sent_per_op[REQ_POP_BACK], sent_per_op[REQ_RESIZE]);
		$display("read %0d, write %0d, dump %0d; %0d result beats compared, %0d flagged",
		         sent_per_op[REQ_READ], sent_per_op[REQ_WRITE], sent_per_op[REQ_DUMP],
		         beats_checked, flagged_beats);
		if (fail_count == 0 && pending == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/ide_pkg.sv
hdl/ide_ram.sv
hdl/ide_ctrl.sv
hdl/indexed_deque_engine_top.sv
test/ide_checker.sv
test/testbench.sv
